### src/imac_pkg.sv
// Shared types and constants for the interval mean accumulator.
// No dependencies; imac_datapath, imac_ctrl and interval_mean_accumulator import this package.
`default_nettype none

package imac_pkg;

  localparam int FUNC_W = 2;
  localparam int CH_W   = 3;
  localparam int PT_W   = 8;
  localparam int VAL_W  = 32;
  localparam int SUM_W  = 48;
  localparam int CNT_W  = 16;

  localparam int DEF_CHANNELS = 8;
  localparam int DEF_POINTS   = 256;

  // transaction function codes
  localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_MEAN  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  // result status codes
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD,
    ST_MLOAD,
    ST_DIV,
    ST_MOUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic add_commit;
    logic div_start;
    logic out_fire;
    logic clr_begin;
    logic clr_step;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cnt_zero;
    logic div_done;
    logic clr_last;
  } dp_stat_t;

endpackage

`default_nettype wire

### src/imac_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module imac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### src/imac_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
`default_nettype none

module imac_div #(
  parameter int DVD_W = 48,
  parameter int DVS_W = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  done,
  output logic      [DVD_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic              running_r, running_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [DVD_W-1:0]  quo_r, quo_nxt;
  logic [DVS_W-1:0]  rem_r, rem_nxt;
  logic [DVS_W-1:0]  dvs_r, dvs_nxt;
  logic [DVS_W:0]    rem_sh;
  logic              fits;

  assign rem_sh   = {rem_r, quo_r[DVD_W-1]};
  assign fits     = rem_sh >= {1'b0, dvs_r};
  assign done     = running_r && (step_r == STEP_W'(1));
  assign quotient = quo_r;

  always_comb begin
    running_nxt = running_r;
    step_nxt    = step_r;
    quo_nxt     = quo_r;
    rem_nxt     = rem_r;
    dvs_nxt     = dvs_r;
    if (start) begin
      running_nxt = 1'b1;
      step_nxt    = STEP_W'(DVD_W);
      quo_nxt     = dividend;
      rem_nxt     = '0;
      dvs_nxt     = divisor;
    end else if (running_r) begin
      // shift one dividend bit in, subtract when the divisor fits
      quo_nxt  = {quo_r[DVD_W-2:0], fits};
      rem_nxt  = fits ? DVS_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[DVS_W-1:0];
      step_nxt = step_r - STEP_W'(1);
      if (done) begin
        running_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      step_r    <= '0;
    end else begin
      running_r <= running_nxt;
      step_r    <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

endmodule

`default_nettype wire

### src/imac_datapath.sv
// Datapath: sum store, saturating adder, sample count, divider, result registers.
// Depends on imac_pkg, imac_ram and imac_div.
`default_nettype none

module imac_datapath #(
  parameter int CHANNELS = imac_pkg::DEF_CHANNELS,
  parameter int POINTS   = imac_pkg::DEF_POINTS
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire imac_pkg::ctrl_cmd_t               cmd,
  output imac_pkg::dp_stat_t                     stat,
  input  wire logic        [imac_pkg::CH_W-1:0]  in_channel,
  input  wire logic        [imac_pkg::PT_W-1:0]  in_point,
  input  wire logic signed [imac_pkg::VAL_W-1:0] in_sample_value,
  input  wire logic                              in_end_of_sample,
  output logic                                   out_valid,
  output logic signed      [imac_pkg::VAL_W-1:0] out_mean_value,
  output logic                                   out_status
);

  import imac_pkg::*;

  localparam int ENTRIES = CHANNELS * POINTS;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic [SUM_W-1:0] Q_POS_LIM = SUM_W'(32'h7FFF_FFFF);
  localparam logic [SUM_W-1:0] Q_NEG_LIM = SUM_W'(33'h1_0000_0000) >> 1;
  localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  logic [IDX_W-1:0] in_idx;
  logic             in_ok;
  logic [IDX_W-1:0] idx_r;
  logic             ok_r;
  logic [VAL_W-1:0] val_r;
  logic             eos_r;
  logic             neg_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] clr_addr_r, clr_addr_nxt;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [SUM_W-1:0] ram_wdata;
  logic [SUM_W-1:0] ram_rdata;

  logic [SUM_W:0]   sum_wide;
  logic [SUM_W-1:0] sum_sat;
  logic [SUM_W-1:0] sum_mag;
  logic [SUM_W-1:0] dividend;
  logic             div_done;
  logic [SUM_W-1:0] quotient;
  logic [VAL_W-1:0] mean_sat;

  logic             out_valid_r;
  logic [VAL_W-1:0] out_mean_r;
  logic             out_status_r;

  assign in_ok  = (32'(in_channel) < 32'(CHANNELS)) && (32'(in_point) < 32'(POINTS));
  assign in_idx = IDX_W'(32'(in_channel) * 32'(POINTS) + 32'(in_point));

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      idx_r <= in_idx;
      ok_r  <= in_ok;
      val_r <= in_sample_value;
      eos_r <= in_end_of_sample;
    end
    if (cmd.div_start) begin
      neg_r <= ok_r && ram_rdata[SUM_W-1];
    end
  end

  // saturating 48-bit accumulate
  assign sum_wide = {ram_rdata[SUM_W-1], ram_rdata} +
                    {{(SUM_W+1-VAL_W){val_r[VAL_W-1]}}, val_r};
  always_comb begin
    sum_sat = sum_wide[SUM_W-1:0];
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_sat = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
    end
  end

  // store write port: clear sweep or add commit
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = sum_sat;
    if (cmd.clr_step) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else if (cmd.add_commit) begin
      ram_we = ok_r;
    end
  end

  imac_ram #(
    .WIDTH(SUM_W),
    .DEPTH(ENTRIES),
    .AW   (IDX_W)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(in_idx),
    .rdata(ram_rdata)
  );

  // sample count and clear sweep address
  always_comb begin
    cnt_nxt      = cnt_r;
    clr_addr_nxt = clr_addr_r;
    if (cmd.clr_begin) begin
      cnt_nxt      = '0;
      clr_addr_nxt = '0;
    end else begin
      if (cmd.add_commit && eos_r && (cnt_r != {CNT_W{1'b1}})) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
      if (cmd.clr_step) begin
        clr_addr_nxt = clr_addr_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      clr_addr_r <= '0;
    end else begin
      cnt_r      <= cnt_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // divide magnitude by count
  assign sum_mag  = ram_rdata[SUM_W-1] ? SUM_W'(~ram_rdata + SUM_W'(1)) : ram_rdata;
  assign dividend = ok_r ? sum_mag : '0;

  imac_div #(
    .DVD_W(SUM_W),
    .DVS_W(CNT_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .dividend(dividend),
    .divisor (cnt_r),
    .done    (div_done),
    .quotient(quotient)
  );

  // restore sign and saturate to 32 bits
  always_comb begin
    if (neg_r) begin
      mean_sat = (quotient > Q_NEG_LIM) ? VAL_MIN : VAL_W'(~quotient + SUM_W'(1));
    end else begin
      mean_sat = (quotient > Q_POS_LIM) ? VAL_MAX : quotient[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.out_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_fire) begin
      out_mean_r   <= (cnt_r == '0) ? '0 : mean_sat;
      out_status_r <= (cnt_r == '0) ? STATUS_EMPTY : STATUS_OK;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_mean_value = out_mean_r;
  assign out_status     = out_status_r;

  assign stat.cnt_zero = (cnt_r == '0);
  assign stat.div_done = div_done;
  assign stat.clr_last = (clr_addr_r == IDX_W'(ENTRIES - 1));

endmodule

`default_nettype wire

### src/imac_ctrl.sv
// Controller state machine: sequences add, mean, clear and the clear sweep.
// Depends on imac_pkg.
`default_nettype none

module imac_ctrl (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic [imac_pkg::FUNC_W-1:0]      in_func,
  input  wire imac_pkg::dp_stat_t               stat,
  output imac_pkg::ctrl_cmd_t                   cmd,
  output logic                                  busy
);

  import imac_pkg::*;

  state_t state_r, state_nxt;
  logic   accept;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (stat.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_func)
            FUNC_ADD:   state_nxt = ST_ADD;
            FUNC_MEAN:  state_nxt = ST_MLOAD;
            FUNC_CLEAR: state_nxt = ST_CLEAR;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ADD:   state_nxt = ST_IDLE;
      ST_MLOAD: state_nxt = stat.cnt_zero ? ST_MOUT : ST_DIV;
      ST_DIV: begin
        if (stat.div_done) begin
          state_nxt = ST_MOUT;
        end
      end
      ST_MOUT:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd            = '0;
    cmd.accept     = accept;
    cmd.clr_begin  = accept && (in_func == FUNC_CLEAR);
    cmd.add_commit = (state_r == ST_ADD);
    cmd.div_start  = (state_r == ST_MLOAD) && !stat.cnt_zero;
    cmd.out_fire   = (state_r == ST_MOUT);
    cmd.clr_step   = (state_r == ST_CLEAR);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

### src/interval_mean_accumulator.sv
// Interval mean accumulator: per-entry running sums with a shared sample count.
// Add: store read at accept, saturating write in the next cycle.
// Mean: load, bit-serial divide by the count (skipped with no samples), then a strobe.
// Clear: the store is swept one entry per cycle.
// Reset (rst_n low, synchronous) zeroes the count and starts the same clearing sweep;
// busy stays high until the sweep ends. The receiver cannot stall results.
`default_nettype none

module interval_mean_accumulator #(
  parameter int CHANNELS = imac_pkg::DEF_CHANNELS,
  parameter int POINTS   = imac_pkg::DEF_POINTS
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic        [imac_pkg::FUNC_W-1:0] in_func,
  input  wire logic        [imac_pkg::CH_W-1:0]  in_channel,
  input  wire logic        [imac_pkg::PT_W-1:0]  in_point,
  input  wire logic signed [imac_pkg::VAL_W-1:0] in_sample_value,
  input  wire logic                              in_end_of_sample,
  output logic                                   out_valid,
  output logic signed      [imac_pkg::VAL_W-1:0] out_mean_value,
  output logic                                   out_status
);

  import imac_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Controller: owns the handshake and walks each transaction through its states.
  imac_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_func(in_func),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  // Datapath: the sum store is read every cycle at the addressed entry, so the
  // entry is ready the cycle after accept for either the add or the mean.
  imac_datapath #(
    .CHANNELS(CHANNELS),
    .POINTS  (POINTS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_channel      (in_channel),
    .in_point        (in_point),
    .in_sample_value (in_sample_value),
    .in_end_of_sample(in_end_of_sample),
    .out_valid       (out_valid),
    .out_mean_value  (out_mean_value),
    .out_status      (out_status)
  );

  // A mean result is a single-cycle strobe.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // The strobe follows the output state, so the block was busy the cycle before.
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a preceding busy cycle");

  // A no-samples result carries a zero mean.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == STATUS_EMPTY)) |-> (out_mean_value == '0))
    else $error("no-samples result with nonzero mean");

  // Leaving reset starts the clearing sweep, so no transaction is taken at once.
  a_reset_sweep: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> busy)
    else $error("block idle right after reset");

endmodule

`default_nettype wire
